[hw/rtl/bsa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bitmap slot allocator: word formats,
// status and register codes, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int REGION_BYTES_DEF  = 65536;
    localparam int MAP_WORD_BITS_DEF = 64;

    localparam int ADDR_W     = 48;
    localparam int STATUS_W   = 3;
    localparam int FREE_W     = 17;
    localparam int LOG2_W     = 5;
    localparam int MAX_LOG2   = 16;
    localparam int RESET_LOG2 = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SIZE_LOG2 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = CFG_IDX_W'(1);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_OUTSIDE      = 3'd2,
        ST_MISALIGNED   = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } t_status;

    typedef struct packed {
        logic              opcode;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] slot_address;
        logic              in_region;
        logic [FREE_W-1:0] free_slots;
    } t_rsp;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } t_cfg;

    typedef struct packed {
        logic fill;
        logic take;
        logic calc;
        logic scan;
        logic take_slot;
        logic free_check;
        logic free_bit;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic refill;
        logic fill_last;
        logic req_accept;
        logic op_free;
        logic empty;
        logic word_hit;
        logic scan_end;
        logic free_good;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

[hw/rtl/bsa_stream.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_stream
// Valid/ready channel carrying one payload word of a given type.
// ----------------------------------------------------------------------------
interface bsa_stream #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/bsa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = bsa_pkg::MAP_WORD_BITS_DEF,
    parameter int DEPTH = bsa_pkg::REGION_BYTES_DEF / bsa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[hw/rtl/bsa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_datapath
// Config registers, free count, bitmap memory, scan pointer, region checks
// and the result register of the slot allocator.
// ----------------------------------------------------------------------------
module bsa_datapath #(
    parameter int REGION_BYTES  = bsa_pkg::REGION_BYTES_DEF,
    parameter int MAP_WORD_BITS = bsa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bsa_stream.sink            i_req,
    bsa_stream.source          o_rsp,
    bsa_stream.sink            i_cfg,
    input  wire bsa_pkg::t_cmd i_cmd,
    output bsa_pkg::t_sts      o_sts
);
    import bsa_pkg::*;

    localparam int WORDS  = REGION_BYTES / MAP_WORD_BITS;
    localparam int WIDX_W = $clog2(WORDS);
    localparam int BIDX_W = $clog2(MAP_WORD_BITS);
    localparam int OFS_W  = $clog2(REGION_BYTES);
    localparam int CNT_W  = OFS_W + 1;
    localparam logic [CNT_W-1:0]  REGION_CNT = CNT_W'(REGION_BYTES);
    localparam logic [CNT_W-1:0]  RESET_CNT  = CNT_W'(REGION_BYTES >> RESET_LOG2);
    localparam logic [CNT_W-1:0]  WORD_CNT   = CNT_W'(MAP_WORD_BITS);
    localparam logic [WIDX_W-1:0] LAST_WORD  = WIDX_W'(WORDS - 1);
    localparam logic [LOG2_W-1:0] LOG2_CAP   = LOG2_W'(MAX_LOG2);

    function automatic logic [BIDX_W-1:0] low_bit(input logic [MAP_WORD_BITS-1:0] w);
        logic [BIDX_W-1:0] b;
        b = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (w[i]) begin
                b = BIDX_W'(i);
            end
        end
        return b;
    endfunction

    logic [LOG2_W-1:0]        r_log2;
    logic [ADDR_W-1:0]        r_base;
    logic [CNT_W-1:0]         r_count;
    logic [WIDX_W-1:0]        r_hint;
    logic [WIDX_W-1:0]        r_fptr;
    logic [WIDX_W-1:0]        r_ptr;
    logic                     r_op;
    logic [ADDR_W-1:0]        r_addr;
    logic                     r_in_region;
    logic [OFS_W-1:0]         r_ofs;
    logic [BIDX_W-1:0]        r_bit;
    logic [MAP_WORD_BITS-1:0] r_word;
    t_status                  r_status;
    logic [ADDR_W-1:0]        r_slot_addr;
    logic                     r_ovalid;
    t_rsp                     r_rsp;

    logic                     cfg_wr;
    logic                     refill;
    logic                     req_acc;
    logic [LOG2_W-1:0]        lg;
    logic [CNT_W-1:0]         n_slots;
    logic [CNT_W-1:0]         fbase;
    logic [CNT_W-1:0]         frem;
    logic [MAP_WORD_BITS-1:0] fpat;
    logic [ADDR_W:0]          diff;
    logic                     calc_in_region;
    logic                     misaligned;
    logic [OFS_W-1:0]         fidx;
    logic                     beyond;
    logic [WIDX_W-1:0]        fword;
    logic [BIDX_W-1:0]        fbit;
    logic [OFS_W-1:0]         slot_idx;
    logic [OFS_W+MAX_LOG2-1:0] slot_ofs;
    logic [MAP_WORD_BITS-1:0] rdata;
    logic                     we;
    logic [WIDX_W-1:0]        waddr;
    logic [MAP_WORD_BITS-1:0] wdata;
    logic [WIDX_W-1:0]        raddr;
    logic                     already_free;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign refill      = cfg_wr && (i_cfg.data.index == CFG_SLOT_SIZE_LOG2);
    assign i_cfg.ready = 1'b1;
    assign i_req.ready = i_cmd.take && !refill;
    assign req_acc     = i_req.valid && i_req.ready;

    assign lg      = (r_log2 > LOG2_CAP) ? LOG2_CAP : r_log2;
    assign n_slots = REGION_CNT >> lg;

    // refill pattern for the word under the fill pointer
    assign fbase = {1'b0, r_fptr, {BIDX_W{1'b0}}};
    assign frem  = n_slots - fbase;
    always_comb begin
        if (n_slots <= fbase) begin
            fpat = '0;
        end else if (frem >= WORD_CNT) begin
            fpat = '1;
        end else begin
            fpat = ~({MAP_WORD_BITS{1'b1}} << frem[BIDX_W-1:0]);
        end
    end

    // free address checks
    assign diff           = {1'b0, r_addr} - {1'b0, r_base};
    assign calc_in_region = !diff[ADDR_W] && (diff[ADDR_W-1:OFS_W] == '0);
    assign misaligned     = |(r_ofs & ~({OFS_W{1'b1}} << lg));
    assign fidx           = r_ofs >> lg;
    assign beyond         = {1'b0, fidx} >= n_slots;
    assign fword          = fidx[OFS_W-1:BIDX_W];
    assign fbit           = fidx[BIDX_W-1:0];
    assign already_free   = rdata[fbit];

    assign slot_idx = {r_ptr, r_bit};
    assign slot_ofs = (OFS_W + MAX_LOG2)'(slot_idx) << lg;

    always_comb begin
        priority if (i_cmd.calc) begin
            raddr = r_hint;
        end else if (i_cmd.scan) begin
            raddr = r_ptr + WIDX_W'(1);
        end else if (i_cmd.free_check) begin
            raddr = fword;
        end else begin
            raddr = r_ptr;
        end
    end

    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = r_word & ~(MAP_WORD_BITS'(1) << r_bit);
        priority if (i_cmd.fill) begin
            we    = 1'b1;
            waddr = r_fptr;
            wdata = fpat;
        end else if (i_cmd.take_slot) begin
            we = 1'b1;
        end else if (i_cmd.free_bit && !already_free) begin
            we    = 1'b1;
            waddr = fword;
            wdata = rdata | (MAP_WORD_BITS'(1) << fbit);
        end
    end

    bsa_ram #(
        .WIDTH (MAP_WORD_BITS),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2   <= LOG2_W'(RESET_LOG2);
            r_base   <= '0;
            r_count  <= RESET_CNT;
            r_hint   <= '0;
            r_fptr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.fill) begin
                r_fptr <= r_fptr + WIDX_W'(1);
                if (r_fptr == LAST_WORD) begin
                    r_count <= n_slots;
                end
            end
            if (i_cmd.take_slot) begin
                r_count <= r_count - CNT_W'(1);
                r_hint  <= r_ptr;
            end
            if (i_cmd.free_bit && !already_free) begin
                r_count <= r_count + CNT_W'(1);
                if (fword < r_hint) begin
                    r_hint <= fword;
                end
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            if (cfg_wr) begin
                if (i_cfg.data.index == CFG_SLOT_SIZE_LOG2) begin
                    r_log2 <= i_cfg.data.value[LOG2_W-1:0];
                    r_fptr <= '0;
                    r_hint <= '0;
                end else if (i_cfg.data.index == CFG_BASE_ADDRESS) begin
                    r_base <= i_cfg.data.value[ADDR_W-1:0];
                end
            end
        end
    end

    // request payload, scan and result registers
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_op   <= i_req.data.opcode;
            r_addr <= i_req.data.address;
        end
        if (i_cmd.calc) begin
            r_ptr       <= r_hint;
            r_ofs       <= diff[OFS_W-1:0];
            r_slot_addr <= '0;
            r_in_region <= (r_op == OP_FREE) && calc_in_region;
            r_status    <= ((r_op == OP_ALLOC) && (r_count == '0)) ? ST_FULL : ST_OK;
        end
        if (i_cmd.scan) begin
            if (|rdata) begin
                r_word <= rdata;
                r_bit  <= low_bit(rdata);
            end else begin
                r_ptr <= r_ptr + WIDX_W'(1);
                if (r_ptr == LAST_WORD) begin
                    r_status <= ST_FULL;
                end
            end
        end
        if (i_cmd.take_slot) begin
            r_slot_addr <= r_base + ADDR_W'(slot_ofs[OFS_W-1:0]);
        end
        if (i_cmd.free_check) begin
            priority if (!r_in_region) begin
                r_status <= ST_OUTSIDE;
            end else if (misaligned) begin
                r_status <= ST_MISALIGNED;
            end else if (beyond) begin
                r_status <= ST_OUTSIDE;
            end else begin
                r_status <= ST_OK;
            end
        end
        if (i_cmd.free_bit && already_free) begin
            r_status <= ST_ALREADY_FREE;
        end
        if (i_cmd.emit) begin
            r_rsp.status       <= r_status;
            r_rsp.slot_address <= r_slot_addr;
            r_rsp.in_region    <= r_in_region;
            r_rsp.free_slots   <= FREE_W'(r_count);
        end
    end

    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    assign o_sts.refill     = refill;
    assign o_sts.fill_last  = (r_fptr == LAST_WORD);
    assign o_sts.req_accept = req_acc;
    assign o_sts.op_free    = (r_op == OP_FREE);
    assign o_sts.empty      = (r_count == '0);
    assign o_sts.word_hit   = |rdata;
    assign o_sts.scan_end   = (r_ptr == LAST_WORD);
    assign o_sts.free_good  = r_in_region && !misaligned && !beyond;
    assign o_sts.out_free   = !r_ovalid || o_rsp.ready;
endmodule
`default_nettype wire

[hw/rtl/bsa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsa_ctrl
// Sequencer of the slot allocator: map refill, allocate scan, free check
// and result hand-off.
// ----------------------------------------------------------------------------
module bsa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bsa_pkg::t_sts i_sts,
    output bsa_pkg::t_cmd      o_cmd
);
    import bsa_pkg::*;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_CALC,
        S_ALLOC_SCAN,
        S_ALLOC_TAKE,
        S_FREE_CHK,
        S_FREE_BIT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.take = 1'b1;
                if (i_sts.req_accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (i_sts.op_free) begin
                    n_state = S_FREE_CHK;
                end else if (i_sts.empty) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_ALLOC_SCAN;
                end
            end
            S_ALLOC_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.word_hit) begin
                    n_state = S_ALLOC_TAKE;
                end else if (i_sts.scan_end) begin
                    n_state = S_EMIT;
                end
            end
            S_ALLOC_TAKE: begin
                o_cmd.take_slot = 1'b1;
                n_state         = S_EMIT;
            end
            S_FREE_CHK: begin
                o_cmd.free_check = 1'b1;
                n_state          = i_sts.free_good ? S_FREE_BIT : S_EMIT;
            end
            S_FREE_BIT: begin
                o_cmd.free_bit = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FILL;
        end else if (i_sts.refill) begin
            r_state <= S_FILL;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/bitmap_slot_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Fixed-size slot allocator over one region, free bitmap held in a RAM.
//
// i_req carries opcode (allocate or free) and a slot address to free; each
// request word gives exactly one o_rsp word with status, allocated address,
// region hit and the free count after the operation. i_cfg writes the slot
// size (refills the map) or the region base; it is always ready.
// A free passes calc, the region and alignment check and, if that passes,
// a bit-set step. An allocate passes calc, a scan of the bitmap words and
// a take step, going straight to emit when the free count is zero; the
// scan starts at the lowest word that may hold a free slot, so words
// emptied earlier are skipped only once. One request is in flight at a
// time; the next request is accepted the cycle after its result is loaded
// into the output register. After reset and every slot size write the map
// is rewritten one word per cycle, REGION_BYTES / MAP_WORD_BITS words (1024
// by default), while i_req is not ready. A stalled o_rsp holds its word; a
// finished result waits in the emit step until the output register frees.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int REGION_BYTES  = bsa_pkg::REGION_BYTES_DEF,
    parameter int MAP_WORD_BITS = bsa_pkg::MAP_WORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bsa_stream.sink   i_req,
    bsa_stream.source o_rsp,
    bsa_stream.sink   i_cfg
);
    import bsa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bsa_datapath #(
        .REGION_BYTES  (REGION_BYTES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );
endmodule
`default_nettype wire
